// ===== rtl/undirected_graph_cycle_detector_top_assert.svh =====
// Assertion macros for the undirected graph cycle detector.
`ifndef UNDIRECTED_GRAPH_CYCLE_DETECTOR_TOP_ASSERT_SVH
`define UNDIRECTED_GRAPH_CYCLE_DETECTOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define UGCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UGCD_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define UGCD_ASSERT(lbl, prop, msg)
`define UGCD_NEVER(lbl, expr, msg)
`endif
`endif

// ===== rtl/ugcd_pkg.sv =====
// Package: shared constants, codes and types of the graph cycle detector.
package ugcd_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int ACTION_W         = 2;
    localparam int VERTEX_W         = 4;
    localparam int COUNT_W          = 5;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

    localparam logic [ACTION_W-1:0] ACT_ADD     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DEL     = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_EDGE_Q  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CYCLE_Q = 2'd3;

    localparam logic KIND_EDGE  = 1'b0;
    localparam logic KIND_CYCLE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_MOD_A,
        ST_RD_B,
        ST_MOD_B,
        ST_ROOT,
        ST_LOAD,
        ST_SCAN,
        ST_POP,
        ST_DONE
    } ugcd_state_t;

endpackage

// ===== rtl/ugcd_ifs.sv =====
// Channel interfaces: command, result and vertex count write.
interface ugcd_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [ugcd_pkg::ACTION_W-1:0] action;
    logic [ugcd_pkg::VERTEX_W-1:0] first_vertex;
    logic [ugcd_pkg::VERTEX_W-1:0] second_vertex;

    modport source (output valid, output action, output first_vertex,
                    output second_vertex, input ready);
    modport sink (input valid, input action, input first_vertex,
                  input second_vertex, output ready);
endinterface

interface ugcd_res_if;
    logic valid;
    logic ready;
    logic query_kind;
    logic answer;

    modport source (output valid, output query_kind, output answer, input ready);
    modport sink (input valid, input query_kind, input answer, output ready);
endinterface

interface ugcd_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [ugcd_pkg::COUNT_W-1:0] vertex_count;

    modport source (output valid, output vertex_count, input ready);
    modport sink (input valid, input vertex_count, output ready);
endinterface

// ===== rtl/undirected_graph_cycle_detector_top.sv =====
// Top level: adjacency memory, DFS sequencer with stack memory, result register.
//
// channel | dir | payload                                  | handshake
// cmd     | in  | action, first_vertex, second_vertex       | valid/ready
// res     | out | query_kind, answer                       | valid/ready
// cfg     | in  | vertex_count                             | valid/ready, always ready
//
// Add/delete: two read-modify-write passes on the adjacency memory (RD_A,
// MOD_A, RD_B, MOD_B); a vertex out of range returns straight to idle.
// Edge query: RD_A, MOD_A, DONE, or straight to DONE out of range. Cycle
// query: DFS scan, one adjacency bit per cycle, plus root, row load, stack pop.
// Reset leaves an empty graph at once (per-row valid bits), no clearing pass.
// A result held in the output register stalls only the next query's last cycle.
`include "undirected_graph_cycle_detector_top_assert.svh"

module undirected_graph_cycle_detector_top #(
    parameter int MAX_VERTICES = ugcd_pkg::MAX_VERTICES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ugcd_cfg_if.sink   cfg,
    ugcd_cmd_if.sink   cmd,
    ugcd_res_if.source res
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int DW = $clog2(MAX_VERTICES + 1);

    typedef struct packed {
        logic [VW-1:0] vtx;
        logic [VW-1:0] par;
        logic          has_par;
        logic [DW-1:0] nxt;
    } frame_t;

    ugcd_pkg::ugcd_state_t state_reg, state_next;

    logic [ugcd_pkg::COUNT_W-1:0]  count_reg;
    logic [ugcd_pkg::ACTION_W-1:0] act_reg, act_next;
    logic [ugcd_pkg::VERTEX_W-1:0] a_reg, a_next;
    logic [ugcd_pkg::VERTEX_W-1:0] b_reg, b_next;
    logic                          ans_reg, ans_next;
    logic [DW-1:0]                 root_reg, root_next;
    logic [MAX_VERTICES-1:0]       visited_reg, visited_next;
    logic [DW-1:0]                 depth_reg, depth_next;
    frame_t                        top_reg, top_next;
    logic [MAX_VERTICES-1:0]       row_reg, row_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_kind_reg, out_kind_next;
    logic                          out_ans_reg, out_ans_next;

    // adjacency memory
    logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] row_valid_reg;
    logic [MAX_VERTICES-1:0] adj_rd_reg;
    logic                    adj_qv_reg;
    logic                    adj_we;
    logic [VW-1:0]           adj_waddr;
    logic [MAX_VERTICES-1:0] adj_wdata;
    logic [VW-1:0]           adj_raddr;
    logic [MAX_VERTICES-1:0] adj_row;

    // stack memory
    frame_t        stk_mem [MAX_VERTICES];
    frame_t        stk_rd_reg;
    logic          stk_we;
    logic [VW-1:0] stk_waddr;
    frame_t        stk_wdata;
    logic [VW-1:0] stk_raddr;

    logic [DW-1:0]           n_use;
    logic                    in_ok;
    logic                    acc;
    logic [VW-1:0]           a_idx, b_idx, w_idx, root_idx;
    logic [MAX_VERTICES-1:0] bit_a, bit_b;
    logic [DW-1:0]           dep_m1, dep_m2;
    logic                    scan_end, scan_new, scan_hit, scan_push;
    logic                    root_end, root_vis, out_free;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= ugcd_pkg::COUNT_RESET;
        else if (cfg.valid)
            count_reg <= cfg.vertex_count;
    end

    assign n_use = (32'(count_reg) > 32'(MAX_VERTICES)) ? DW'(MAX_VERTICES)
                                                        : DW'(count_reg);

    // command decode
    assign cmd.ready = (state_reg == ugcd_pkg::ST_IDLE);
    assign acc       = cmd.valid && cmd.ready;
    assign in_ok     = (32'(cmd.first_vertex) < 32'(n_use)) &&
                       (32'(cmd.second_vertex) < 32'(n_use));

    assign a_idx    = VW'(a_reg);
    assign b_idx    = VW'(b_reg);
    assign w_idx    = VW'(top_reg.nxt);
    assign root_idx = VW'(root_reg);
    assign bit_a    = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << a_idx;
    assign bit_b    = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << b_idx;
    assign dep_m1   = depth_reg - DW'(1);
    assign dep_m2   = depth_reg - DW'(2);
    assign adj_row  = adj_qv_reg ? adj_rd_reg : '0;

    assign scan_end  = top_reg.nxt >= n_use;
    assign scan_new  = !scan_end && row_reg[w_idx] &&
                       !(top_reg.has_par && (w_idx == top_reg.par));
    assign scan_hit  = scan_new && visited_reg[w_idx];
    assign scan_push = scan_new && !visited_reg[w_idx] && (depth_reg < DW'(MAX_VERTICES));
    assign root_end  = root_reg >= n_use;
    assign root_vis  = visited_reg[root_idx];
    assign out_free  = !out_valid_reg || res.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ugcd_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    case (cmd.action)
                        ugcd_pkg::ACT_ADD,
                        ugcd_pkg::ACT_DEL:
                            state_next = in_ok ? ugcd_pkg::ST_RD_A : ugcd_pkg::ST_IDLE;
                        ugcd_pkg::ACT_EDGE_Q:
                            state_next = in_ok ? ugcd_pkg::ST_RD_A : ugcd_pkg::ST_DONE;
                        default:
                            state_next = ugcd_pkg::ST_ROOT;
                    endcase
                end
            end
            ugcd_pkg::ST_RD_A:
                state_next = ugcd_pkg::ST_MOD_A;
            ugcd_pkg::ST_MOD_A:
                state_next = (act_reg == ugcd_pkg::ACT_EDGE_Q) ? ugcd_pkg::ST_DONE
                                                               : ugcd_pkg::ST_RD_B;
            ugcd_pkg::ST_RD_B:
                state_next = ugcd_pkg::ST_MOD_B;
            ugcd_pkg::ST_MOD_B:
                state_next = ugcd_pkg::ST_IDLE;
            ugcd_pkg::ST_ROOT:
            begin
                if (root_end)
                    state_next = ugcd_pkg::ST_DONE;
                else if (!root_vis)
                    state_next = ugcd_pkg::ST_LOAD;
            end
            ugcd_pkg::ST_LOAD:
                state_next = ugcd_pkg::ST_SCAN;
            ugcd_pkg::ST_SCAN:
            begin
                if (scan_end)
                    state_next = (depth_reg == DW'(1)) ? ugcd_pkg::ST_ROOT : ugcd_pkg::ST_POP;
                else if (scan_hit)
                    state_next = ugcd_pkg::ST_DONE;
                else if (scan_push)
                    state_next = ugcd_pkg::ST_LOAD;
            end
            ugcd_pkg::ST_POP:
                state_next = ugcd_pkg::ST_LOAD;
            ugcd_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = ugcd_pkg::ST_IDLE;
            end
            default:
                state_next = ugcd_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        act_next       = act_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        ans_next       = ans_reg;
        root_next      = root_reg;
        visited_next   = visited_reg;
        depth_next     = depth_reg;
        top_next       = top_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_kind_next  = out_kind_reg;
        out_ans_next   = out_ans_reg;
        adj_we         = 1'b0;
        adj_waddr      = a_idx;
        adj_wdata      = adj_row | bit_b;
        adj_raddr      = a_idx;
        stk_we         = 1'b0;
        stk_waddr      = dep_m1[VW-1:0];
        stk_wdata      = top_reg;
        stk_raddr      = dep_m2[VW-1:0];

        case (state_reg)
            ugcd_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    act_next     = cmd.action;
                    a_next       = cmd.first_vertex;
                    b_next       = cmd.second_vertex;
                    ans_next     = 1'b0;
                    root_next    = '0;
                    visited_next = '0;
                    depth_next   = '0;
                end
            end
            ugcd_pkg::ST_RD_A:
                adj_raddr = a_idx;
            ugcd_pkg::ST_MOD_A:
            begin
                if (act_reg == ugcd_pkg::ACT_EDGE_Q)
                    ans_next = adj_row[b_idx];
                else
                begin
                    adj_we    = 1'b1;
                    adj_waddr = a_idx;
                    adj_wdata = (act_reg == ugcd_pkg::ACT_ADD) ? (adj_row | bit_b)
                                                               : (adj_row & ~bit_b);
                end
            end
            ugcd_pkg::ST_RD_B:
                adj_raddr = b_idx;
            ugcd_pkg::ST_MOD_B:
            begin
                adj_we    = 1'b1;
                adj_waddr = b_idx;
                adj_wdata = (act_reg == ugcd_pkg::ACT_ADD) ? (adj_row | bit_a)
                                                           : (adj_row & ~bit_a);
            end
            ugcd_pkg::ST_ROOT:
            begin
                adj_raddr = root_idx;
                if (!root_end)
                begin
                    if (root_vis)
                        root_next = root_reg + DW'(1);
                    else
                    begin
                        visited_next[root_idx] = 1'b1;
                        top_next.vtx     = root_idx;
                        top_next.par     = '0;
                        top_next.has_par = 1'b0;
                        top_next.nxt     = '0;
                        depth_next       = DW'(1);
                    end
                end
            end
            ugcd_pkg::ST_LOAD:
                row_next = adj_row;
            ugcd_pkg::ST_SCAN:
            begin
                adj_raddr = w_idx;
                if (scan_end)
                begin
                    depth_next = dep_m1;
                    if (depth_reg == DW'(1))
                        root_next = root_reg + DW'(1);
                end
                else
                begin
                    top_next.nxt = top_reg.nxt + DW'(1);
                    if (scan_hit)
                    begin
                        ans_next   = 1'b1;
                        depth_next = '0;
                    end
                    else if (scan_new)
                    begin
                        visited_next[w_idx] = 1'b1;
                        if (scan_push)
                        begin
                            stk_we           = 1'b1;
                            stk_wdata.nxt    = top_reg.nxt + DW'(1);
                            top_next.vtx     = w_idx;
                            top_next.par     = top_reg.vtx;
                            top_next.has_par = 1'b1;
                            top_next.nxt     = '0;
                            depth_next       = depth_reg + DW'(1);
                        end
                    end
                end
            end
            ugcd_pkg::ST_POP:
            begin
                top_next  = stk_rd_reg;
                adj_raddr = stk_rd_reg.vtx;
            end
            ugcd_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = (act_reg == ugcd_pkg::ACT_CYCLE_Q) ? ugcd_pkg::KIND_CYCLE
                                                                        : ugcd_pkg::KIND_EDGE;
                    out_ans_next   = ans_reg;
                end
            end
            default:
            begin
                adj_we = 1'b0;
                stk_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ugcd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            depth_reg     <= '0;
            root_reg      <= '0;
            visited_reg   <= '0;
            row_valid_reg <= '0;
            adj_qv_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            depth_reg     <= depth_next;
            root_reg      <= root_next;
            visited_reg   <= visited_next;
            adj_qv_reg    <= row_valid_reg[adj_raddr];
            if (adj_we)
                row_valid_reg[adj_waddr] <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        ans_reg      <= ans_next;
        top_reg      <= top_next;
        row_reg      <= row_next;
        out_kind_reg <= out_kind_next;
        out_ans_reg  <= out_ans_next;
    end

    // adjacency rows, one read and one write port
    always_ff @(posedge clk)
    begin
        if (adj_we)
            adj_mem[adj_waddr] <= adj_wdata;
        adj_rd_reg <= adj_mem[adj_raddr];
    end

    // DFS frames below the top of stack
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        stk_rd_reg <= stk_mem[stk_raddr];
    end

    assign res.valid      = out_valid_reg;
    assign res.query_kind = out_kind_reg;
    assign res.answer     = out_ans_reg;

    `UGCD_ASSERT(a_depth_bound, depth_reg <= DW'(MAX_VERTICES), "stack depth above limit")
    `UGCD_NEVER(a_scan_empty, state_reg == ugcd_pkg::ST_SCAN && depth_reg == '0, "empty scan")
    `UGCD_ASSERT(a_load_vis, state_reg == ugcd_pkg::ST_LOAD |-> visited_reg[top_reg.vtx], "bad load")
    `UGCD_ASSERT(a_res_done, $rose(out_valid_reg) |-> $past(state_reg) == ugcd_pkg::ST_DONE, "no done")

endmodule
